// ===== rtl/lfka_pkg.sv =====
package lfka_pkg;

    localparam int TABLE_WORDS  = 32;
    localparam int IDX_W        = $clog2(TABLE_WORDS);
    localparam int IDX_P1       = IDX_W + 1;
    localparam int WORD_W       = 32;
    localparam int WARMUP_STEPS = 310;
    localparam int WARM_W       = $clog2(WARMUP_STEPS + 2);

    // park-miller minimal standard constants
    localparam int QUOT_W = 15;
    localparam int MUL_W  = 32;
    localparam logic [WORD_W-1:0] PM_Q     = 32'd127773;
    localparam logic [QUOT_W-1:0] PM_A     = 15'd16807;
    localparam logic [QUOT_W-1:0] PM_R     = 15'd2836;

    // reciprocal of PM_Q scaled by 2^RCP_SH, the estimate is low by at most one
    localparam int RCP_SH = 40;
    localparam int RCP_W  = 24;
    localparam int PROD_W = WORD_W + RCP_W;
    localparam logic [RCP_W-1:0] PM_RCP = RCP_W'((64'd1 << RCP_SH) / 64'd127773);

    localparam int LAG_SHORT = 3;
    localparam int SEED_LAST = TABLE_WORDS - 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef struct packed {
        logic  en;
        idx_t  addr;
        word_t data;
    } tbl_wr_t;

endpackage

// ===== rtl/lfka_in_if.sv =====
interface lfka_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, action, data_byte, input ready);
    modport sink (input valid, action, data_byte, output ready);
endinterface

// ===== rtl/lfka_out_if.sv =====
interface lfka_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] coded_byte;

    modport source (output valid, coded_byte, input ready);
    modport sink (input valid, coded_byte, output ready);
endinterface

// ===== rtl/lfka_cfg_if.sv =====
interface lfka_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seed;

    modport source (output valid, seed, input ready);
    modport sink (input valid, seed, output ready);
endinterface

// ===== rtl/lfka_table.sv =====
module lfka_table (
    input  logic             clk,
    input  logic             rst_n,
    input  lfka_pkg::tbl_wr_t wr,
    input  lfka_pkg::idx_t   rd_addr_a,
    input  lfka_pkg::idx_t   rd_addr_b,
    output lfka_pkg::word_t  rd_data_a,
    output lfka_pkg::word_t  rd_data_b
);

    lfka_pkg::word_t mem [lfka_pkg::TABLE_WORDS];
    lfka_pkg::word_t a_reg;
    lfka_pkg::word_t b_reg;
    logic [lfka_pkg::TABLE_WORDS-1:0] valid_reg;
    logic va_reg;
    logic vb_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        a_reg <= mem[rd_addr_a];
        b_reg <= mem[rd_addr_b];
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            va_reg <= valid_reg[rd_addr_a];
            vb_reg <= valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = va_reg ? a_reg : '0;
    assign rd_data_b = vb_reg ? b_reg : '0;

endmodule

// ===== rtl/lfka_pm_unit.sv =====
module lfka_pm_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lfka_pkg::word_t x,
    output logic            done,
    output lfka_pkg::word_t y
);

    typedef enum logic [3:0] {
        P_IDLE,
        P_RCP,
        P_QD,
        P_FIX,
        P_MUL1,
        P_MUL2,
        P_SUB,
        P_FIN,
        P_DONE
    } pm_state_t;

    pm_state_t                     state_reg;
    lfka_pkg::word_t               rem_reg;
    logic [lfka_pkg::QUOT_W-1:0]   quot_reg;
    logic                          neg_reg;
    logic [lfka_pkg::MUL_W-1:0]    p1_reg;
    logic [lfka_pkg::MUL_W-1:0]    p2_reg;
    logic signed [33:0]            t_reg;
    lfka_pkg::word_t               y_reg;

    lfka_pkg::word_t               x_mag;
    lfka_pkg::word_t               mul_a;
    logic [lfka_pkg::RCP_W-1:0]    mul_b;
    logic [lfka_pkg::PROD_W-1:0]   prod;
    logic signed [33:0]            t_fix;

    // truncating division works on the magnitude, sign applied afterwards
    assign x_mag = x[31] ? (~x + 32'd1) : x;

    // one multiplier shared by quotient estimate, back-multiply and both products
    assign mul_a = (state_reg == P_QD || state_reg == P_MUL2)
                 ? lfka_pkg::WORD_W'(quot_reg) : rem_reg;
    always_comb
    begin
        case (state_reg)
            P_RCP:   mul_b = lfka_pkg::PM_RCP;
            P_QD:    mul_b = lfka_pkg::RCP_W'(lfka_pkg::PM_Q);
            P_MUL1:  mul_b = lfka_pkg::RCP_W'(lfka_pkg::PM_A);
            default: mul_b = lfka_pkg::RCP_W'(lfka_pkg::PM_R);
        endcase
    end
    assign prod  = lfka_pkg::PROD_W'(mul_a) * lfka_pkg::PROD_W'(mul_b);

    assign t_fix = t_reg + 34'sh07fffffff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            rem_reg   <= '0;
            quot_reg  <= '0;
            neg_reg   <= 1'b0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            t_reg     <= '0;
            y_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                P_IDLE, P_DONE:
                begin
                    // a new start may follow the done cycle directly
                    if (start)
                    begin
                        rem_reg   <= x_mag;
                        quot_reg  <= '0;
                        neg_reg   <= x[31];
                        state_reg <= P_RCP;
                    end
                    else
                    begin
                        state_reg <= P_IDLE;
                    end
                end
                P_RCP:
                begin
                    quot_reg  <= prod[lfka_pkg::RCP_SH +: lfka_pkg::QUOT_W];
                    state_reg <= P_QD;
                end
                P_QD:
                begin
                    rem_reg   <= rem_reg - prod[lfka_pkg::WORD_W-1:0];
                    state_reg <= P_FIX;
                end
                P_FIX:
                begin
                    // estimate may be one short
                    if (rem_reg >= lfka_pkg::PM_Q)
                    begin
                        rem_reg  <= rem_reg - lfka_pkg::PM_Q;
                        quot_reg <= quot_reg + 1'b1;
                    end
                    state_reg <= P_MUL1;
                end
                P_MUL1:
                begin
                    p1_reg    <= prod[lfka_pkg::MUL_W-1:0];
                    state_reg <= P_MUL2;
                end
                P_MUL2:
                begin
                    p2_reg    <= prod[lfka_pkg::MUL_W-1:0];
                    state_reg <= P_SUB;
                end
                P_SUB:
                begin
                    if (neg_reg)
                    begin
                        t_reg <= $signed({2'b00, p2_reg}) - $signed({2'b00, p1_reg});
                    end
                    else
                    begin
                        t_reg <= $signed({2'b00, p1_reg}) - $signed({2'b00, p2_reg});
                    end
                    state_reg <= P_FIN;
                end
                P_FIN:
                begin
                    y_reg     <= (t_reg <= 34'sd0) ? t_fix[31:0] : t_reg[31:0];
                    state_reg <= P_DONE;
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == P_DONE);
    assign y    = y_reg;

endmodule

// ===== rtl/lagged_fibonacci_keystream_adder_top.sv =====
// byte coder built on an additive lagged-fibonacci generator (lags 31 and 3) over a
// 32-word table. an input beat with action 1 codes data_byte: one generator step
// adds word[rear] into word[front], bits 31..1 of the new word taken mod 255 are
// added to the byte, and one coded_byte beat comes out once the input beat has
// passed accept, table read, table write and the output register, the last of which
// waits while the previous output beat is not yet taken; din.ready is low until
// the result is loaded, so no new byte is taken before then. an input beat with
// action 0 reseeds from the seed register and gives no output beat: word 0 takes
// the seed, words 1..30 come from a park-miller unit that divides by reciprocal
// multiply on one shared multiplier, then WARMUP_STEPS generator steps run, each
// a read state and a write state through the table's registered read port.
// the seed register may be written at any time the block is idle; it is
// picked up at the next reseed. before any reseed the table reads as zero.
module lagged_fibonacci_keystream_adder_top (
    input logic        clk,
    input logic        rst_n,
    lfka_in_if.sink    din,
    lfka_out_if.source dout,
    lfka_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_WARM_RD,
        S_WARM_WR,
        S_BYTE_RD,
        S_BYTE_WR,
        S_OUT
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    lfka_pkg::idx_t             front_reg;
    lfka_pkg::idx_t             front_next;
    lfka_pkg::idx_t             rear_reg;
    lfka_pkg::idx_t             rear_next;
    lfka_pkg::idx_t             seed_idx_reg;
    lfka_pkg::idx_t             seed_idx_next;
    logic [lfka_pkg::WARM_W-1:0] warm_cnt_reg;
    logic [lfka_pkg::WARM_W-1:0] warm_cnt_next;
    logic [7:0]                 data_reg;
    logic [7:0]                 data_next;
    logic [30:0]                key_src_reg;
    logic [30:0]                key_src_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [7:0]                 coded_reg;
    logic [7:0]                 coded_next;
    lfka_pkg::word_t            seed_reg;

    lfka_pkg::tbl_wr_t          tbl_wr;
    lfka_pkg::word_t            rd_front;
    lfka_pkg::word_t            rd_rear;
    lfka_pkg::word_t            step_sum;
    lfka_pkg::idx_t             front_adv;
    lfka_pkg::idx_t             rear_adv;
    logic [lfka_pkg::IDX_P1-1:0] front_inc;
    logic [lfka_pkg::IDX_P1-1:0] rear_inc;
    logic                       pm_start;
    logic                       pm_done;
    lfka_pkg::word_t            pm_x;
    lfka_pkg::word_t            pm_y;
    logic [9:0]                 fold1;
    logic [8:0]                 fold2;
    logic [8:0]                 key_mod;

    // lag table: both reads addressed by the current indices, data in the following cycle
    lfka_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .rd_addr_a (front_reg),
        .rd_addr_b (rear_reg),
        .rd_data_a (rd_front),
        .rd_data_b (rd_rear)
    );

    // park-miller step, fed from the seed first and then from its own result
    lfka_pm_unit u_pm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pm_start),
        .x     (pm_x),
        .done  (pm_done),
        .y     (pm_y)
    );

    assign pm_x     = (state_reg == S_IDLE) ? seed_reg : pm_y;
    assign step_sum = rd_front + rd_rear;

    // index advance: front wraps to 1 and drags rear along, rear alone wraps to 1
    assign front_inc = lfka_pkg::IDX_P1'(front_reg) + 1'b1;
    assign rear_inc  = lfka_pkg::IDX_P1'(rear_reg) + 1'b1;
    always_comb
    begin
        if (front_inc == lfka_pkg::IDX_P1'(lfka_pkg::TABLE_WORDS))
        begin
            front_adv = lfka_pkg::IDX_W'(1);
            rear_adv  = rear_inc[lfka_pkg::IDX_W-1:0];
        end
        else
        begin
            front_adv = front_inc[lfka_pkg::IDX_W-1:0];
            rear_adv  = (rear_inc == lfka_pkg::IDX_P1'(lfka_pkg::TABLE_WORDS))
                        ? lfka_pkg::IDX_W'(1) : rear_inc[lfka_pkg::IDX_W-1:0];
        end
    end

    // keystream mod 255: byte digits summed twice since 256 is 1 mod 255
    assign fold1   = 10'(key_src_reg[7:0]) + 10'(key_src_reg[15:8])
                   + 10'(key_src_reg[23:16]) + 10'(key_src_reg[30:24]);
    assign fold2   = 9'(fold1[7:0]) + 9'(fold1[9:8]);
    assign key_mod = (fold2 >= 9'd255) ? (fold2 - 9'd255) : fold2;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        seed_idx_next  = seed_idx_reg;
        warm_cnt_next  = warm_cnt_reg;
        data_next      = data_reg;
        key_src_next   = key_src_reg;
        out_valid_next = out_valid_reg;
        coded_next     = coded_reg;
        tbl_wr.en      = 1'b0;
        tbl_wr.addr    = front_reg;
        tbl_wr.data    = step_sum;
        pm_start       = 1'b0;

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    if (din.action)
                    begin
                        data_next  = din.data_byte;
                        state_next = S_BYTE_RD;
                    end
                    else
                    begin
                        // word 0 takes the seed, the pm unit starts on it right away
                        tbl_wr.en     = 1'b1;
                        tbl_wr.addr   = '0;
                        tbl_wr.data   = seed_reg;
                        pm_start      = 1'b1;
                        seed_idx_next = lfka_pkg::IDX_W'(1);
                        state_next    = S_SEED;
                    end
                end
            end
            S_SEED:
            begin
                if (pm_done)
                begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = seed_idx_reg;
                    tbl_wr.data = pm_y;
                    if (seed_idx_reg == lfka_pkg::IDX_W'(lfka_pkg::SEED_LAST))
                    begin
                        // word 31 keeps its old value
                        front_next    = lfka_pkg::IDX_W'(lfka_pkg::LAG_SHORT);
                        rear_next     = '0;
                        warm_cnt_next = lfka_pkg::WARM_W'(lfka_pkg::WARMUP_STEPS);
                        state_next    = (lfka_pkg::WARMUP_STEPS == 0) ? S_IDLE : S_WARM_RD;
                    end
                    else
                    begin
                        seed_idx_next = seed_idx_reg + 1'b1;
                        pm_start      = 1'b1;
                    end
                end
            end
            S_WARM_RD:
            begin
                state_next = S_WARM_WR;
            end
            S_WARM_WR:
            begin
                tbl_wr.en     = 1'b1;
                front_next    = front_adv;
                rear_next     = rear_adv;
                warm_cnt_next = warm_cnt_reg - 1'b1;
                state_next    = (warm_cnt_reg == lfka_pkg::WARM_W'(1)) ? S_IDLE : S_WARM_RD;
            end
            S_BYTE_RD:
            begin
                state_next = S_BYTE_WR;
            end
            S_BYTE_WR:
            begin
                tbl_wr.en    = 1'b1;
                front_next   = front_adv;
                rear_next    = rear_adv;
                key_src_next = step_sum[31:1];
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // hold here while the previous beat is still waiting downstream
                if (!out_valid_reg || dout.ready)
                begin
                    out_valid_next = 1'b1;
                    coded_next     = data_reg + key_mod[7:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= lfka_pkg::IDX_W'(4);
            rear_reg      <= lfka_pkg::IDX_W'(1);
            seed_idx_reg  <= '0;
            warm_cnt_reg  <= '0;
            data_reg      <= '0;
            key_src_reg   <= '0;
            out_valid_reg <= 1'b0;
            coded_reg     <= '0;
            seed_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            seed_idx_reg  <= seed_idx_next;
            warm_cnt_reg  <= warm_cnt_next;
            data_reg      <= data_next;
            key_src_reg   <= key_src_next;
            out_valid_reg <= out_valid_next;
            coded_reg     <= coded_next;
            if (cfg.valid)
            begin
                seed_reg <= cfg.seed;
            end
        end
    end

    assign din.ready       = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign dout.valid      = out_valid_reg;
    assign dout.coded_byte = coded_reg;

    // every input beat takes the sequencer out of idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready |=> state_reg != S_IDLE)
        else $error("input beat accepted without leaving idle");

    // front never lands on word 0 after reset, reseed or advance
    a_front_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg != '0)
        else $error("front index reached word 0");

    // park-miller results only arrive while seeding
    a_pm_done_seed: assert property (@(posedge clk) disable iff (!rst_n)
        pm_done |-> state_reg == S_SEED)
        else $error("park-miller result outside seeding");

    // an output beat appears only from the output state
    a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output beat without a coded byte step");

    // table is untouched while idle with no beat taken
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && !din.valid |-> !tbl_wr.en)
        else $error("table write while idle");

endmodule

// ===== dv/tb_lagged_fibonacci_keystream_adder_top.sv =====
module tb_lagged_fibonacci_keystream_adder_top;

    // action field of an input beat
    typedef enum logic {
        ACT_RESEED = 1'b0,
        ACT_CODE   = 1'b1
    } action_e;

    // park-miller minimal standard, kept in 64-bit signed arithmetic
    localparam longint PM_QUOT = 127773;
    localparam longint PM_MULT = 16807;
    localparam longint PM_RMD  = 2836;
    localparam longint PM_MOD  = 64'h7fffffff;
    localparam int     KEY_MOD = 255;

    // a reseed gives no output beat, so this settle time is meant to cover it
    localparam int SETTLE_CYCLES   = 1400;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 12000;
    localparam int PHASE_COUNT     = 7;
    localparam int ITEMS_PER_PHASE = 105;

    // keeps its own copy of the generator and the coded bytes still due
    class keystream_board;
        lfka_pkg::word_t lag_tbl [lfka_pkg::TABLE_WORDS];
        lfka_pkg::idx_t  front;
        lfka_pkg::idx_t  rear;
        lfka_pkg::word_t seed_reg;
        logic [7:0]      coded_due [$];
        int              mismatches;

        function new();
            foreach (lag_tbl[i])
                lag_tbl[i] = '0;
            front      = lfka_pkg::idx_t'(4);
            rear       = lfka_pkg::idx_t'(1);
            seed_reg   = '0;
            mismatches = 0;
        endfunction

        function lfka_pkg::word_t pm_next(lfka_pkg::word_t w);
            longint x;
            longint hi;
            longint lo;
            longint y;
            x  = longint'($signed(w));
            hi = x / PM_QUOT;
            lo = x % PM_QUOT;
            y  = PM_MULT * lo - PM_RMD * hi;
            if (y <= 0)
                y += PM_MOD;
            return lfka_pkg::word_t'(y);
        endfunction

        // one additive step, then front and rear advance
        function lfka_pkg::word_t lf_step();
            lfka_pkg::word_t keyval;
            int              nf;
            int              nr;
            lag_tbl[front] = lag_tbl[front] + lag_tbl[rear];
            keyval = lag_tbl[front] >> 1;
            nf = front + 1;
            if (nf >= lfka_pkg::TABLE_WORDS)
            begin
                nf = 1;
                nr = (rear + 1) % lfka_pkg::TABLE_WORDS;
            end
            else
            begin
                nr = rear + 1;
                if (nr >= lfka_pkg::TABLE_WORDS)
                    nr = 1;
            end
            front = lfka_pkg::idx_t'(nf);
            rear  = lfka_pkg::idx_t'(nr);
            return keyval;
        endfunction

        // word 31 is left alone on purpose
        function void reseed_table();
            lag_tbl[0] = seed_reg;
            for (int i = 1; i < lfka_pkg::TABLE_WORDS - 1; i++)
                lag_tbl[i] = pm_next(lag_tbl[i-1]);
            front = lfka_pkg::idx_t'(lfka_pkg::LAG_SHORT);
            rear  = '0;
            repeat (lfka_pkg::WARMUP_STEPS)
                void'(lf_step());
        endfunction

        function void note_input(logic act, logic [7:0] plain);
            lfka_pkg::word_t keyval;
            lfka_pkg::word_t sum;
            if (act == ACT_RESEED)
                reseed_table();
            else
            begin
                keyval = lf_step();
                sum    = lfka_pkg::word_t'(plain) + (keyval % KEY_MOD);
                coded_due.push_back(sum[7:0]);
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch @%0t: %s", $time, what);
            mismatches++;
        endtask

        task check_coded(logic [7:0] got);
            logic [7:0] want;
            if (coded_due.size() == 0)
                report_mismatch($sformatf("coded_byte %02h with nothing due", got));
            else
            begin
                want = coded_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("coded_byte got %02h want %02h", got, want));
            end
        endtask

        function int pending();
            return coded_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lfka_in_if  din_if();
    lfka_out_if dout_if();
    lfka_cfg_if cfg_if();

    lagged_fibonacci_keystream_adder_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if),
        .cfg   (cfg_if)
    );

    keystream_board board = new();

    int unsigned idle_cycles = 0;   // cycles since the last beat on any channel
    bit          hold_req    = 1'b0; // asks the receiver for one long hold-off
    bit          steady_send = 1'b0; // no gaps between input beats
    int          burst_left  = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // every accepted beat is seen here, with values from before the edge
    always @(posedge clk)
    begin
        if (rst_n && ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)
                      || (cfg_if.valid && cfg_if.ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
                board.check_coded(dout_if.coded_byte);
            if (din_if.valid && din_if.ready)
                board.note_input(din_if.action, din_if.data_byte);
            if (cfg_if.valid && cfg_if.ready)
                board.seed_reg = cfg_if.seed;
        end
    end

    // ends a hung run
    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: ready follows a random mode, redrawn along with its mask; a hold request stalls it for a long stretch
    initial
    begin : receiver
        int         mode;
        int         cyc;
        logic [7:0] mask;
        mode = 0;
        cyc  = 0;
        mask = 8'hb5;
        dout_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                dout_if.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                cyc++;
                if (cyc % 64 == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mask = 8'($urandom_range(1, 255));
                end
                mask = {mask[6:0], mask[7]};
                case (mode)
                    0:       dout_if.ready <= 1'b1;
                    1:       dout_if.ready <= 1'($urandom_range(0, 1));
                    2:       dout_if.ready <= mask[0];
                    default: dout_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offers one input beat and returns at the edge that takes it
    task automatic send_beat(action_e act, logic [7:0] plain);
        din_if.valid     <= 1'b1;
        din_if.action    <= act;
        din_if.data_byte <= plain;
        do
            @(posedge clk);
        while (!din_if.ready);
    endtask

    // bursts of random length, random gaps between them unless steady
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if (!steady_send)
            begin
                din_if.valid <= 1'b0;
                repeat ($urandom_range(1, 7))
                    @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        din_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // seed is only written once nothing is in flight, a reseed included
    task automatic write_seed(logic [31:0] value);
        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.seed  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic code_byte(logic [7:0] plain);
        send_beat(ACT_CODE, plain);
        pace_sender();
    endtask

    task automatic reseed(logic [7:0] junk);
        send_beat(ACT_RESEED, junk);
        pace_sender();
    endtask

    initial
    begin : stimulus
        logic [31:0] phase_seed [PHASE_COUNT];
        rst_n            <= 1'b0;
        din_if.valid     <= 1'b0;
        din_if.action    <= ACT_CODE;
        din_if.data_byte <= 8'h00;
        cfg_if.valid     <= 1'b0;
        cfg_if.seed      <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coding before any reseed runs on the zero table
        code_byte(8'h00);
        code_byte(8'hff);
        code_byte(8'h5a);
        // reseed with the reset seed of zero; data_byte is ignored
        reseed(8'hff);
        code_byte(8'h00);
        code_byte(8'hff);
        code_byte(8'h80);
        code_byte(8'h7f);

        // most negative seed, and two reseeds back to back
        write_seed(32'h8000_0000);
        reseed(8'h00);
        reseed(8'haa);
        code_byte(8'hff);
        code_byte(8'h00);
        code_byte(8'h01);

        write_seed(32'h7fff_ffff);
        reseed(8'h55);
        code_byte(8'hfe);
        code_byte(8'h00);
        code_byte(8'hff);

        write_seed(32'hffff_ffff);
        reseed(8'h00);
        code_byte(8'h3c);
        code_byte(8'hc3);

        phase_seed[0] = $urandom();
        phase_seed[1] = 32'h7fff_ffff;
        phase_seed[2] = $urandom();
        phase_seed[3] = $urandom();
        phase_seed[4] = 32'h8000_0000;
        phase_seed[5] = $urandom();
        phase_seed[6] = 32'h0000_0000;

        // random phases: mostly reseed followed by a byte run, with stray reseeds
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_seed(phase_seed[p]);
            steady_send = (p == 1 || p == 5);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // one long receiver hold-off while the sender keeps offering
                if (p == 2 && n == 40)
                    hold_req = 1'b1;
                // sender waits until every coded byte is back
                if (p == 3 && n == 50)
                    drain_results();
                // the last phase leads with bytes on the old table state
                if ((n == 0 && p != PHASE_COUNT - 1) || $urandom_range(0, 99) < 4)
                    reseed(8'($urandom_range(0, 255)));
                else
                    code_byte(8'($urandom_range(0, 255)));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d coded bytes never came", board.pending()));
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
